### rtl/assert_macros.svh
// concurrent assertion helpers, clocked on clk, quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### rtl/bclp_pkg.sv
package bclp_pkg;

  localparam int LANES    = 5;
  localparam int KEY_W    = 5;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd7;

  // reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] MULTI_RST    = 16'd100;
  localparam logic [CFG_W-1:0] LONG_RST [LANES] = '{16'd2000, 16'd1500, 16'd3000,
                                                    16'd1500, 16'd1500};
  localparam logic [KEY_W-1:0] MASK_RST     = 5'd30;

  // status codes
  localparam logic [STATUS_W-1:0] ST_IDLE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SINGLE_REL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_REL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SINGLE_PRS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE_PRS = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LONG       = 3'd5;

  // debounced level transitions, {after, before}
  localparam logic [1:0] TR_RELEASED = 2'b00;
  localparam logic [1:0] TR_RELEASE  = 2'b01;
  localparam logic [1:0] TR_PRESS    = 2'b10;
  localparam logic [1:0] TR_HELD     = 2'b11;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] multi_click_ticks;
  } bclp_cfg_t;

  typedef logic [LANES-1:0][STATUS_W-1:0] bclp_status_t;

endpackage

### rtl/bclp_ifs.sv
interface bclp_in_if import bclp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_levels;

  modport source(output valid, output key_levels, input ready);
  modport sink(input valid, input key_levels, output ready);
endinterface

interface bclp_out_if import bclp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] key0_status;
  logic [STATUS_W-1:0] key1_status;
  logic [STATUS_W-1:0] key2_status;
  logic [STATUS_W-1:0] key3_status;
  logic [STATUS_W-1:0] key4_status;

  modport source(output valid, output key0_status, output key1_status,
                 output key2_status, output key3_status, output key4_status,
                 input ready);
  modport sink(input valid, input key0_status, input key1_status,
               input key2_status, input key3_status, input key4_status,
               output ready);
endinterface

### rtl/button_click_longpress_detector.sv
// channel   dir  payload                          handshake
// in_ch     in   key_levels[4:0]                   valid / ready
// out_ch    out  key0_status .. key4_status [2:0]  valid / ready
// cfg       in   cfg_idx[2:0], cfg_wdata[15:0]     cfg_we, no wait
//
// one tick per cycle while in_ch.ready is high; each status item is registered
// each key has its own lane that updates debounce and click state on each tick
// a two-entry output buffer keeps in_ch.ready high while one result is stalled
// rst_n is synchronous; restores register defaults, clears key state but not
// start times; no clearing pass after reset, ticks are taken on the next cycle
module button_click_longpress_detector import bclp_pkg::*; #(
  parameter int KEYS       = 5,
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bclp_in_if.sink              in_ch,
  bclp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  bclp_cfg_t             cfg_r;
  logic [CFG_W-1:0]      long_r [LANES];
  logic [KEY_W-1:0]      mask_r;
  logic [TIME_WIDTH-1:0] tick_r;
  logic                  step;
  logic                  ready;
  bclp_status_t          lane_status;

  assign in_ch.ready = ready;
  assign step        = in_ch.valid && ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= DEBOUNCE_RST;
      cfg_r.multi_click_ticks <= MULTI_RST;
      mask_r                  <= MASK_RST;
      for (int k = 0; k < LANES; k++) begin
        long_r[k] <= LONG_RST[k];
      end
    end else if (cfg_we) begin
      if (cfg_idx == CFG_DEBOUNCE) cfg_r.debounce_ticks <= cfg_wdata;
      if (cfg_idx == CFG_MULTI) cfg_r.multi_click_ticks <= cfg_wdata;
      if (cfg_idx == CFG_MASK) mask_r <= cfg_wdata[KEY_W-1:0];
      for (int k = 0; k < LANES; k++) begin
        if (cfg_idx == CFG_IDX_W'(int'(CFG_LONG0) + k)) long_r[k] <= cfg_wdata;
      end
    end
  end

  // holds the time of the next tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TIME_WIDTH'(1);
    end else if (step) begin
      tick_r <= tick_r + TIME_WIDTH'(1);
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    if (k < KEYS) begin : g_on
      bclp_lane #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .raw        (in_ch.key_levels[k] ^ mask_r[k]),
        .now        (tick_r),
        .cfg        (cfg_r),
        .long_ticks (long_r[k]),
        .status_nxt (lane_status[k])
      );
    end else begin : g_off
      assign lane_status[k] = ST_IDLE;
    end
  end

  bclp_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (step),
    .din    (lane_status),
    .ready  (ready),
    .out_ch (out_ch)
  );

endmodule

### rtl/bclp_lane.sv
`include "assert_macros.svh"

module bclp_lane import bclp_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  raw,
  input  logic [TIME_WIDTH-1:0] now,
  input  bclp_cfg_t             cfg,
  input  logic [CFG_W-1:0]      long_ticks,
  output logic [STATUS_W-1:0]   status_nxt
);

  logic                  lvl_r, lvl_nxt;
  logic                  run_r, run_nxt;
  logic [TIME_WIDTH-1:0] deb_start_r, deb_start_nxt;
  logic [TIME_WIDTH-1:0] prs_start_r, prs_start_nxt;
  logic [TIME_WIDTH-1:0] rel_start_r, rel_start_nxt;
  logic [1:0]            prs_cnt_r, prs_cnt_nxt;
  logic [1:0]            rel_cnt_r, rel_cnt_nxt;
  logic [STATUS_W-1:0]   status_r;

  logic [TIME_WIDTH-1:0] deb_el, prs_el, rel_el;
  logic                  deb_exp, prs_win, rel_win, prs_long;

  assign deb_el   = now - deb_start_r;
  assign prs_el   = now - prs_start_r;
  assign rel_el   = now - rel_start_r;
  assign deb_exp  = deb_el > TIME_WIDTH'(cfg.debounce_ticks);
  assign prs_win  = prs_el >= TIME_WIDTH'(cfg.multi_click_ticks);
  assign rel_win  = rel_el >= TIME_WIDTH'(cfg.multi_click_ticks);
  assign prs_long = prs_el >= TIME_WIDTH'(long_ticks);

  always_comb begin
    lvl_nxt       = lvl_r;
    run_nxt       = run_r;
    deb_start_nxt = deb_start_r;
    prs_start_nxt = prs_start_r;
    rel_start_nxt = rel_start_r;
    prs_cnt_nxt   = prs_cnt_r;
    rel_cnt_nxt   = rel_cnt_r;
    status_nxt    = status_r;

    // debounce
    if (raw != lvl_r) begin
      if (!run_r) begin
        run_nxt       = 1'b1;
        deb_start_nxt = now;
      end else if (deb_exp) begin
        lvl_nxt = raw;
        run_nxt = 1'b0;
      end
    end else begin
      run_nxt = 1'b0;
    end

    unique case ({lvl_nxt, lvl_r})
      TR_RELEASED: begin
        status_nxt = ST_IDLE;
        if (prs_cnt_r != 2'd0 && prs_win) begin
          status_nxt  = {1'b0, prs_cnt_r} + ST_DOUBLE_REL;
          prs_cnt_nxt = 2'd0;
        end
        // release wins
        if (rel_cnt_r != 2'd0 && rel_win) begin
          status_nxt  = {1'b0, rel_cnt_r};
          rel_cnt_nxt = 2'd0;
        end
      end
      TR_RELEASE: begin
        if (rel_cnt_r == 2'd0) rel_start_nxt = now;
        rel_cnt_nxt = (rel_cnt_r == 2'd2) ? 2'd0 : rel_cnt_r + 2'd1;
      end
      TR_PRESS: begin
        if (prs_cnt_r == 2'd0) prs_start_nxt = now;
        prs_cnt_nxt = (prs_cnt_r == 2'd2) ? 2'd0 : prs_cnt_r + 2'd1;
      end
      TR_HELD: begin
        if (prs_cnt_r != 2'd0 && prs_long) begin
          status_nxt  = ST_LONG;
          prs_cnt_nxt = 2'd0;
          rel_cnt_nxt = 2'd2;
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r     <= 1'b0;
      run_r     <= 1'b0;
      prs_cnt_r <= 2'd0;
      rel_cnt_r <= 2'd0;
      status_r  <= ST_IDLE;
    end else if (step) begin
      lvl_r     <= lvl_nxt;
      run_r     <= run_nxt;
      prs_cnt_r <= prs_cnt_nxt;
      rel_cnt_r <= rel_cnt_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      deb_start_r <= deb_start_nxt;
      prs_start_r <= prs_start_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_mod3, prs_cnt_r != 2'd3 && rel_cnt_r != 2'd3, "click counter out of range")
  `ASSERT_CLK(a_status_code, status_r <= ST_LONG, "bad key status code")
  `ASSERT_NEXT(a_run_clear, step && (lvl_nxt != lvl_r), !run_r, "debounce timer left running")

endmodule

### rtl/bclp_merge.sv
`include "assert_macros.svh"

module bclp_merge import bclp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bclp_status_t  din,
  output logic          ready,
  bclp_out_if.source    out_ch
);

  logic         main_vld_r, main_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  bclp_status_t main_r, main_nxt;
  bclp_status_t skid_r, skid_nxt;
  logic         pop;

  assign pop   = main_vld_r && out_ch.ready;
  assign ready = !skid_vld_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || pop) begin
      if (skid_vld_r) begin
        main_vld_nxt = 1'b1;
        main_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = din;
      end else begin
        main_vld_nxt = push;
        main_nxt     = din;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid       = main_vld_r;
  assign out_ch.key0_status = main_r[0];
  assign out_ch.key1_status = main_r[1];
  assign out_ch.key2_status = main_r[2];
  assign out_ch.key3_status = main_r[3];
  assign out_ch.key4_status = main_r[4];

  `ASSERT_CLK(a_skid_order, !skid_vld_r || main_vld_r, "skid full while output empty")
  `ASSERT_NEXT(a_fill, push && !main_vld_r, main_vld_r, "request lost on empty output")
  `ASSERT_NEXT(a_no_drop, push && main_vld_r && !out_ch.ready, skid_vld_r,
               "request lost while output stalled")

endmodule

### dv/button_click_longpress_detector_tb.sv
`timescale 1ns / 100ps

module button_click_longpress_detector_tb;
  import bclp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  bclp_in_if in_ch ();
  bclp_out_if out_ch ();

  button_click_longpress_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // key lane model
  logic [CFG_W-1:0] deb_ticks;
  logic [CFG_W-1:0] win_ticks;
  logic [CFG_W-1:0] hold_ticks [LANES];
  logic [KEY_W-1:0] act_low;
  logic [31:0] tick_now;
  logic [LANES-1:0] deb_lvl;
  logic [LANES-1:0] deb_run;
  logic [31:0] deb_t0 [LANES];
  logic [31:0] prs_t0 [LANES];
  logic [31:0] rel_t0 [LANES];
  logic [1:0] prs_n [LANES];
  logic [1:0] rel_n [LANES];
  logic [STATUS_W-1:0] key_st [LANES];

  bclp_status_t pending_status [$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int hold_off_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit [KEY_W-1:0] pin_lvl = '0;
  int pin_left [LANES] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_hold(int deb, int win, int lng);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(1, deb + 1);
    if (r < 6) return $urandom_range(deb + 2, deb + win + 3);
    if (r < 8) return $urandom_range(deb + win + 2, deb + win + 10);
    return lng + deb + $urandom_range(2, 8);
  endfunction

  task automatic reset_lanes();
    deb_ticks = DEBOUNCE_RST;
    win_ticks = MULTI_RST;
    act_low = MASK_RST;
    tick_now = '0;
    deb_lvl = '0;
    deb_run = '0;
    for (int k = 0; k < LANES; k++) begin
      hold_ticks[k] = LONG_RST[k];
      deb_t0[k] = '0;
      prs_t0[k] = '0;
      rel_t0[k] = '0;
      prs_n[k] = '0;
      rel_n[k] = '0;
      key_st[k] = ST_IDLE;
    end
  endtask

  task automatic store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_DEBOUNCE: deb_ticks = val;
      CFG_MULTI: win_ticks = val;
      CFG_MASK: act_low = val[KEY_W-1:0];
      default: hold_ticks[idx - CFG_LONG0] = val;
    endcase
  endtask

  task automatic advance_key_lanes(input logic [KEY_W-1:0] lv);
    bclp_status_t st;
    logic raw;
    logic lvl_old;
    logic lvl_new;
    tick_now = tick_now + 32'd1;
    for (int k = 0; k < LANES; k++) begin
      raw = lv[k] ^ act_low[k];
      lvl_old = deb_lvl[k];
      lvl_new = lvl_old;
      if (raw != lvl_old) begin
        if (!deb_run[k]) begin
          deb_run[k] = 1'b1;
          deb_t0[k] = tick_now;
        end else if (32'(tick_now - deb_t0[k]) > 32'(deb_ticks)) begin
          lvl_new = raw;
          deb_run[k] = 1'b0;
        end
      end else begin
        deb_run[k] = 1'b0;
      end
      deb_lvl[k] = lvl_new;
      case ({lvl_new, lvl_old})
        TR_RELEASED: begin
          key_st[k] = ST_IDLE;
          if (prs_n[k] != 0 && 32'(tick_now - prs_t0[k]) >= 32'(win_ticks)) begin
            key_st[k] = (prs_n[k] == 2) ? ST_DOUBLE_PRS : ST_SINGLE_PRS;
            prs_n[k] = '0;
          end
          if (rel_n[k] != 0 && 32'(tick_now - rel_t0[k]) >= 32'(win_ticks)) begin
            key_st[k] = (rel_n[k] == 2) ? ST_DOUBLE_REL : ST_SINGLE_REL;
            rel_n[k] = '0;
          end
        end
        TR_RELEASE: begin
          if (rel_n[k] == 0) rel_t0[k] = tick_now;
          rel_n[k] = (rel_n[k] == 2) ? 2'd0 : rel_n[k] + 2'd1;
        end
        TR_PRESS: begin
          if (prs_n[k] == 0) prs_t0[k] = tick_now;
          prs_n[k] = (prs_n[k] == 2) ? 2'd0 : prs_n[k] + 2'd1;
        end
        default: begin
          if (prs_n[k] != 0 && 32'(tick_now - prs_t0[k]) >= 32'(hold_ticks[k])) begin
            key_st[k] = ST_LONG;
            prs_n[k] = '0;
            rel_n[k] = 2'd2;
          end
        end
      endcase
      st[k] = key_st[k];
    end
    pending_status.push_back(st);
  endtask

  task automatic check_status();
    bclp_status_t want;
    logic [STATUS_W-1:0] got [LANES];
    got[0] = out_ch.key0_status;
    got[1] = out_ch.key1_status;
    got[2] = out_ch.key2_status;
    got[3] = out_ch.key3_status;
    got[4] = out_ch.key4_status;
    if (pending_status.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10) $display("status item with nothing pending at %0t", $realtime);
    end else begin
      want = pending_status.pop_front();
      for (int k = 0; k < LANES; k++) begin
        if (got[k] !== want[k]) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("key%0d status mismatch at %0t: expected %0d, got %0d",
                     k, $realtime, want[k], got[k]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lanes();
    end else begin
      if (cfg_we) store_reg(cfg_idx, cfg_wdata);
      if (in_ch.valid && in_ch.ready) advance_key_lanes(in_ch.key_levels);
      if (out_ch.valid && out_ch.ready) check_status();
    end
  end

  // result side
  initial begin : status_sink
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if (!rx_gaps) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_tick(input logic [KEY_W-1:0] lv);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.key_levels <= KEY_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key_levels <= lv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // let a clock edge pass first so the last accepted request is already queued
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(int deb, int win, int lng0, int lng_step,
                               logic [CFG_W-1:0] mask_word);
    settle();
    write_reg(CFG_DEBOUNCE, CFG_W'(deb));
    write_reg(CFG_MULTI, CFG_W'(win));
    for (int k = 0; k < LANES; k++)
      write_reg(CFG_LONG0 + CFG_IDX_W'(k), CFG_W'(lng0 + k * lng_step));
    write_reg(CFG_MASK, mask_word);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // held levels of random length per key, with glitches and noise mixed in
  task automatic run_random_clicks(int n, int deb, int win, int lng);
    logic [KEY_W-1:0] lv;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < LANES; k++) begin
        if (pin_left[k] == 0) begin
          pin_lvl[k] = ~pin_lvl[k];
          pin_left[k] = pick_hold(deb, win, lng);
        end
        pin_left[k]--;
      end
      lv = pin_lvl;
      if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
      if ($urandom_range(0, 19) == 0) lv = KEY_W'($urandom);
      send_tick(lv);
    end
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_off_cycles = 80;
    for (int i = 0; i < 40; i++)
      send_tick((i < 25) ? 5'b00001 : 5'b11110);
    tx_gaps = 1'b1;
    settle();
  endtask

  task automatic test_directed_clicks();
    logic [KEY_W-1:0] lv;
    apply_setting(0, 2, 4, 16, 16'h0010);
    for (int t = 0; t < 24; t++) begin
      lv[0] = (t >= 1 && t <= 9);
      lv[1] = (t >= 1 && t <= 2);
      lv[2] = (t >= 1 && t <= 2) || (t >= 5 && t <= 6);
      lv[3] = (t == 3) || (t >= 20);
      lv[4] = !(t >= 12 && t <= 14);
      send_tick(lv);
    end
    send_tick(5'b11111);
    send_tick(5'b00000);
    settle();
  endtask

  task automatic test_random_clicks();
    apply_setting(1, 6, 10, 3, 16'($urandom));
    run_random_clicks(130, 1, 6, 22);
    apply_setting(3, 15, 25, 5, 16'($urandom));
    run_random_clicks(130, 3, 15, 45);
    apply_setting(0, 1, 3, 1, 16'($urandom));
    run_random_clicks(130, 0, 1, 7);
    settle();
  endtask

  task automatic test_register_extremes();
    apply_setting(65535, 65535, 65535, 0, 16'hFFFF);
    run_random_clicks(30, 1, 4, 8);
    apply_setting(0, 0, 0, 0, 16'h0000);
    run_random_clicks(80, 0, 2, 2);
    settle();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.key_levels <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_backpressure();
    test_directed_clicks();
    test_random_clicks();
    test_register_extremes();

    settle();
    if (pending_status.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bclp_pkg.sv
rtl/bclp_ifs.sv
rtl/bclp_lane.sv
rtl/bclp_merge.sv
rtl/button_click_longpress_detector.sv
dv/button_click_longpress_detector_tb.sv
